### rtl/crc_checked_frame_receiver_core_defines.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef CRC_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CRCFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/crcfr_pkg.sv
// Types and constants of the CRC-checked frame receiver.
`timescale 1ns / 1ps
package crcfr_pkg;

  typedef enum logic [2:0] {
    OUT_TELEMETRY = 3'd0,
    OUT_POSITION  = 3'd1,
    OUT_UNUSED    = 3'd2,
    OUT_TAIL_ERR  = 3'd3,
    OUT_CRC_ERR   = 3'd4
  } outcome_t;

  // Configuration register indexes
  localparam logic CFG_TELEM_ID = 1'b0;
  localparam logic CFG_POS_ID   = 1'b1;
  localparam int   CFG_IDX_W    = 1;
  localparam int   CFG_DATA_W   = 8;

  localparam logic [7:0] TELEM_ID_RST = 8'd69;
  localparam logic [7:0] POS_ID_RST   = 8'd87;

  // Frame for the finished tail byte, handed from front to back
  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  frame_id;
    logic [7:0]  body_length;
    logic [15:0] mos_temp;
    logic [15:0] motor_temp;
    logic [31:0] current;
    logic [31:0] erpm;
    logic [15:0] voltage;
    logic [7:0]  fault;
    logic [31:0] tele_pos;
  } frame_rec_t;

endpackage

### rtl/crcfr_front.sv
// Byte-level deframer: header hunt, CRC, field capture and classification.
`timescale 1ns / 1ps
module crcfr_front
  import crcfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_full,
  output logic                  push,
  output frame_rec_t            rec
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_BODY   = 3'd2,
    PH_CRC_HI = 3'd3,
    PH_CRC_LO = 3'd4,
    PH_TAIL   = 3'd5
  } phase_t;

  localparam logic [7:0] HDR_BYTE      = 8'hAA;
  localparam logic [7:0] TAIL_BYTE     = 8'hBB;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0] TELEM_MIN_LEN = 8'd58;
  localparam logic [7:0] POS_MIN_LEN   = 8'd5;

  // Body byte offsets of the kept fields
  localparam logic [7:0] OFS_MOS_LO   = 8'd1;
  localparam logic [7:0] OFS_MOS_HI   = 8'd2;
  localparam logic [7:0] OFS_MOT_LO   = 8'd3;
  localparam logic [7:0] OFS_MOT_HI   = 8'd4;
  localparam logic [7:0] OFS_CUR_LO   = 8'd5;
  localparam logic [7:0] OFS_CUR_HI   = 8'd8;
  localparam logic [7:0] OFS_ERPM_LO  = 8'd23;
  localparam logic [7:0] OFS_ERPM_HI  = 8'd26;
  localparam logic [7:0] OFS_VOLT_LO  = 8'd27;
  localparam logic [7:0] OFS_VOLT_HI  = 8'd28;
  localparam logic [7:0] OFS_FAULT    = 8'd53;
  localparam logic [7:0] OFS_POS_LO   = 8'd54;
  localparam logic [7:0] OFS_POS_HI   = 8'd57;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  phase_t      phase_r;
  logic [7:0]  frame_length_r;
  logic [7:0]  bytes_taken_r;
  logic [7:0]  bytes_taken_nxt;
  logic [15:0] crc_r;
  logic [15:0] rx_crc_r;
  logic [7:0]  id_r;
  logic [7:0]  telem_id_r;
  logic [7:0]  pos_id_r;
  logic [15:0] mos_r;
  logic [15:0] motor_r;
  logic [31:0] cur_r;
  logic [31:0] erpm_r;
  logic [15:0] volt_r;
  logic [7:0]  fault_r;
  logic [31:0] tpos_r;
  logic        accept;

  assign in_stall        = q_full;
  assign accept          = in_valid && !q_full;
  assign bytes_taken_nxt = bytes_taken_r + 8'd1;
  assign push            = accept && (phase_r == PH_TAIL);

  // Classification at the tail byte
  always_comb begin
    rec.frame_id    = id_r;
    rec.body_length = frame_length_r;
    rec.mos_temp    = mos_r;
    rec.motor_temp  = motor_r;
    rec.current     = cur_r;
    rec.erpm        = erpm_r;
    rec.voltage     = volt_r;
    rec.fault       = fault_r;
    rec.tele_pos    = tpos_r;
    if (in_rx_byte != TAIL_BYTE) begin
      rec.outcome = OUT_TAIL_ERR;
    end else if (crc_r != rx_crc_r) begin
      rec.outcome = OUT_CRC_ERR;
    end else if (id_r == telem_id_r) begin
      rec.outcome = (frame_length_r >= TELEM_MIN_LEN) ? OUT_TELEMETRY : OUT_UNUSED;
    end else if (id_r == pos_id_r) begin
      rec.outcome = (frame_length_r >= POS_MIN_LEN) ? OUT_POSITION : OUT_UNUSED;
    end else begin
      rec.outcome = OUT_UNUSED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      telem_id_r <= TELEM_ID_RST;
      pos_id_r   <= POS_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TELEM_ID: telem_id_r <= cfg_wdata;
        CFG_POS_ID:   pos_id_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      frame_length_r <= '0;
      bytes_taken_r  <= '0;
      crc_r          <= '0;
      rx_crc_r       <= '0;
      id_r           <= '0;
    end else if (accept) begin
      case (phase_r)
        PH_LEN: begin
          if (in_rx_byte == 8'd0) begin
            phase_r <= PH_HEADER;
          end else begin
            frame_length_r <= in_rx_byte;
            bytes_taken_r  <= '0;
            crc_r          <= '0;
            phase_r        <= PH_BODY;
          end
        end
        PH_BODY: begin
          if (bytes_taken_r == 8'd0) id_r <= in_rx_byte;
          crc_r         <= crc_step(crc_r, in_rx_byte);
          bytes_taken_r <= bytes_taken_nxt;
          if (bytes_taken_nxt >= frame_length_r) phase_r <= PH_CRC_HI;
        end
        PH_CRC_HI: begin
          rx_crc_r <= {in_rx_byte, 8'h00};
          phase_r  <= PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rx_crc_r[7:0] <= in_rx_byte;
          phase_r       <= PH_TAIL;
        end
        PH_TAIL: phase_r <= PH_HEADER;
        default: begin
          if (in_rx_byte == HDR_BYTE) phase_r <= PH_LEN;
          else phase_r <= PH_HEADER;
        end
      endcase
    end
  end

  // Field capture: big-endian fields shift in as their bytes pass
  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_BODY)) begin
      case (bytes_taken_r) inside
        [OFS_MOS_LO:OFS_MOS_HI]:   mos_r   <= {mos_r[7:0], in_rx_byte};
        [OFS_MOT_LO:OFS_MOT_HI]:   motor_r <= {motor_r[7:0], in_rx_byte};
        [OFS_CUR_LO:OFS_CUR_HI]:   cur_r   <= {cur_r[23:0], in_rx_byte};
        [OFS_ERPM_LO:OFS_ERPM_HI]: erpm_r  <= {erpm_r[23:0], in_rx_byte};
        [OFS_VOLT_LO:OFS_VOLT_HI]: volt_r  <= {volt_r[7:0], in_rx_byte};
        OFS_FAULT:                 fault_r <= in_rx_byte;
        [OFS_POS_LO:OFS_POS_HI]:   tpos_r  <= {tpos_r[23:0], in_rx_byte};
        default: ;
      endcase
    end
  end

endmodule

### rtl/crcfr_queue.sv
// Small record queue between the deframer and the result stage.
`timescale 1ns / 1ps
module crcfr_queue
  import crcfr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output frame_rec_t q_rec
);

  `include "crc_checked_frame_receiver_core_defines.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_rec   = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  `CRCFR_ASSERT_NOW(a_no_overflow, push, !full, "queue push while full")
  `CRCFR_ASSERT_NOW(a_no_underflow, pop, q_valid, "queue pop while empty")
  `CRCFR_ASSERT_NOW(a_full_ptrs, full, wr_ptr_r == rd_ptr_r, "full queue with pointers apart")

endmodule

### rtl/crcfr_back.sv
// Result stage: masks fields by outcome and holds the output register.
`timescale 1ns / 1ps
module crcfr_back
  import crcfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  frame_rec_t         q_rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_outcome,
  output logic [7:0]         out_frame_id,
  output logic [7:0]         out_body_length,
  output logic signed [15:0] out_mos_temp_tenths,
  output logic signed [15:0] out_motor_temp_tenths,
  output logic signed [31:0] out_current_hundredths,
  output logic signed [31:0] out_electrical_rpm,
  output logic signed [15:0] out_voltage_tenths,
  output logic [7:0]         out_fault_code,
  output logic [31:0]        out_position_bits
);

  `include "crc_checked_frame_receiver_core_defines.svh"

  logic        valid_r;
  outcome_t    outcome_r;
  logic [7:0]  id_r;
  logic [7:0]  len_r;
  logic [15:0] mos_r;
  logic [15:0] motor_r;
  logic [31:0] cur_r;
  logic [31:0] erpm_r;
  logic [15:0] volt_r;
  logic [7:0]  fault_r;
  logic [31:0] pos_r;
  logic        is_tele;

  assign pop     = q_valid && (!valid_r || !out_stall);
  assign is_tele = (q_rec.outcome == OUT_TELEMETRY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome_r <= q_rec.outcome;
      id_r      <= q_rec.frame_id;
      len_r     <= q_rec.body_length;
      mos_r     <= is_tele ? q_rec.mos_temp   : '0;
      motor_r   <= is_tele ? q_rec.motor_temp : '0;
      cur_r     <= is_tele ? q_rec.current    : '0;
      erpm_r    <= is_tele ? q_rec.erpm       : '0;
      volt_r    <= is_tele ? q_rec.voltage    : '0;
      fault_r   <= is_tele ? q_rec.fault      : '0;
      case (q_rec.outcome)
        OUT_TELEMETRY: pos_r <= q_rec.tele_pos;
        OUT_POSITION:  pos_r <= {q_rec.mos_temp, q_rec.motor_temp};
        default:       pos_r <= '0;
      endcase
    end
  end

  assign out_valid              = valid_r;
  assign out_outcome            = outcome_r;
  assign out_frame_id           = id_r;
  assign out_body_length        = len_r;
  assign out_mos_temp_tenths    = $signed(mos_r);
  assign out_motor_temp_tenths  = $signed(motor_r);
  assign out_current_hundredths = $signed(cur_r);
  assign out_electrical_rpm     = $signed(erpm_r);
  assign out_voltage_tenths     = $signed(volt_r);
  assign out_fault_code         = fault_r;
  assign out_position_bits      = pos_r;

  `CRCFR_ASSERT_NOW(a_pos_masked, valid_r && (outcome_r == OUT_POSITION), (cur_r == '0) && (erpm_r == '0) && (fault_r == '0), "position result carries telemetry fields")
  `CRCFR_ASSERT_NOW(a_err_masked, valid_r && (outcome_r != OUT_TELEMETRY) && (outcome_r != OUT_POSITION), (pos_r == '0) && (mos_r == '0), "unused or error result carries fields")
  `CRCFR_ASSERT_NEXT(a_load_shows, pop, valid_r, "loaded record not presented")

endmodule

### rtl/crc_checked_frame_receiver_core.sv
// Top level of the CRC-checked serial frame receiver.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid / in_stall  | in_rx_byte
//   out     | output    | out_valid / out_stall| outcome, id, length, telemetry
//   cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One byte transfer per cycle while in_stall is low; the CRC step and field
// capture both fit in that cycle. A result is presented on out_* after the tail
// byte transfer, via the queue write and then the output register load.
// in_stall rises only when the record queue (QUEUE_DEPTH frames) is full.
// Synchronous active-low reset; no memory clearing pass, ready right after reset.
`timescale 1ns / 1ps
module crc_checked_frame_receiver_core
  import crcfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_outcome,
  output logic [7:0]            out_frame_id,
  output logic [7:0]            out_body_length,
  output logic signed [15:0]    out_mos_temp_tenths,
  output logic signed [15:0]    out_motor_temp_tenths,
  output logic signed [31:0]    out_current_hundredths,
  output logic signed [31:0]    out_electrical_rpm,
  output logic signed [15:0]    out_voltage_tenths,
  output logic [7:0]            out_fault_code,
  output logic [31:0]           out_position_bits,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  frame_rec_t push_rec;
  frame_rec_t q_rec;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;

  // Front: header hunt, length, body CRC, field capture, outcome decision
  crcfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .push       (push),
    .rec        (push_rec)
  );

  // Finished frames wait here so the byte side keeps running under out_stall until the queue fills
  crcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_rec    (q_rec)
  );

  // Back: masks fields per outcome into the output register
  crcfr_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_rec                  (q_rec),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_outcome            (out_outcome),
    .out_frame_id           (out_frame_id),
    .out_body_length        (out_body_length),
    .out_mos_temp_tenths    (out_mos_temp_tenths),
    .out_motor_temp_tenths  (out_motor_temp_tenths),
    .out_current_hundredths (out_current_hundredths),
    .out_electrical_rpm     (out_electrical_rpm),
    .out_voltage_tenths     (out_voltage_tenths),
    .out_fault_code         (out_fault_code),
    .out_position_bits      (out_position_bits)
  );

endmodule
